// File: rtl/pdm_pkg.sv
// Shared types and helpers for the pairwise difference median unit.
// No dependencies; used by the controller, datapath and top level.
package pdm_pkg;

	// configuration register fields
	localparam int CFG_BITS = 6;
	localparam int IDX_BITS = 2;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_FIRST_COUNT  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_SECOND_COUNT = 2'd1;

	// controller to datapath commands
	typedef struct packed {
		logic wr_first;     // store a first-sample word
		logic wr_second;    // store a second-sample word
		logic found_clear;  // start of a new selection
		logic cand_latch;   // take read difference as candidate
		logic acc_en;       // rank-count the read difference
		logic eval;         // check candidate against the middle ranks
		logic result_load;  // build the doubled median
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic lo_ok;
		logic hi_ok;
	} stat_t;

	// zero counts as one, large counts saturate at the store depth
	function automatic int clamp_count(input logic [CFG_BITS-1:0] c, input int maxv);
		int r;
		r = int'(c);
		if (r == 0) begin
			r = 1;
		end else if (r > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

endpackage

// File: rtl/pdm_datapath.sv
// Datapath: sample stores, candidate difference, rank counters, result.
// Depends on pdm_pkg.
module pdm_datapath #(
	parameter int MAX_FIRST  = 32,
	parameter int MAX_SECOND = 32,
	parameter int VALUE_BITS = 24,
	parameter int FW  = 5,
	parameter int SW  = 5,
	parameter int FCW = 6,
	parameter int SCW = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pdm_pkg::cmd_t                 cmd,
	output pdm_pkg::stat_t                stat,
	input  logic signed [VALUE_BITS-1:0]  sample_value,
	input  logic [FW-1:0]                 wr_addr_f,
	input  logic [SW-1:0]                 wr_addr_s,
	input  logic [FW-1:0]                 rd_addr_f,
	input  logic [SW-1:0]                 rd_addr_s,
	input  logic [FCW-1:0]                f_cnt,
	input  logic [SCW-1:0]                s_cnt,
	output logic signed [VALUE_BITS+1:0]  median_doubled
);
	import pdm_pkg::*;

	localparam int DW = VALUE_BITS + 1;
	localparam int NW = $clog2(MAX_FIRST * MAX_SECOND + 1);

	logic signed [VALUE_BITS-1:0] first_mem [MAX_FIRST];
	logic signed [VALUE_BITS-1:0] second_mem [MAX_SECOND];
	logic signed [VALUE_BITS-1:0] a_q, b_q;
	logic signed [DW-1:0] diff, cand_q, lo_q, hi_q;
	logic [NW-1:0] less_q, le_q, n_pairs, r_lo, r_hi;
	logic lo_found_q, hi_found_q, hit_lo, hit_hi;

	// sample stores with registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_first) begin
			first_mem[wr_addr_f] <= sample_value;
		end
		if (cmd.wr_second) begin
			second_mem[wr_addr_s] <= sample_value;
		end
		a_q <= first_mem[rd_addr_f];
		b_q <= second_mem[rd_addr_s];
	end

	assign diff = DW'(a_q) - DW'(b_q);

	// middle ranks: (n-1)/2 and n/2
	assign n_pairs = NW'(f_cnt) * NW'(s_cnt);
	assign r_lo    = (n_pairs - NW'(1)) >> 1;
	assign r_hi    = n_pairs >> 1;

	// candidate holds the middle rank when less <= r < less_or_equal
	assign hit_lo = cmd.eval && (less_q <= r_lo) && (r_lo < le_q);
	assign hit_hi = cmd.eval && (less_q <= r_hi) && (r_hi < le_q);
	assign stat.lo_ok = lo_found_q | hit_lo;
	assign stat.hi_ok = hi_found_q | hit_hi;

	// found flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_found_q <= 1'b0;
			hi_found_q <= 1'b0;
		end else if (cmd.found_clear) begin
			lo_found_q <= 1'b0;
			hi_found_q <= 1'b0;
		end else begin
			if (hit_lo) lo_found_q <= 1'b1;
			if (hit_hi) hi_found_q <= 1'b1;
		end
	end

	// candidate, rank counters and result
	always_ff @(posedge clk) begin
		if (cmd.cand_latch) begin
			cand_q <= diff;
			less_q <= '0;
			le_q   <= '0;
		end else if (cmd.acc_en) begin
			if (diff < cand_q)  less_q <= less_q + NW'(1);
			if (diff <= cand_q) le_q   <= le_q + NW'(1);
		end
		if (hit_lo) lo_q <= cand_q;
		if (hit_hi) hi_q <= cand_q;
		if (cmd.result_load) begin
			median_doubled <= (VALUE_BITS+2)'(lo_q) + (VALUE_BITS+2)'(hi_q);
		end
	end

endmodule

// File: rtl/pdm_ctrl.sv
// Controller: load sequencing and candidate/sweep loops of the selection.
// Depends on pdm_pkg.
module pdm_ctrl #(
	parameter int MAX_FIRST  = 32,
	parameter int MAX_SECOND = 32,
	parameter int FW  = 5,
	parameter int SW  = 5,
	parameter int FCW = 6,
	parameter int SCW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr,
	input  logic [FCW-1:0]  f_cnt,
	input  logic [SCW-1:0]  s_cnt,
	input  logic            sample_valid,
	output logic            sample_stall,
	output logic            median_valid,
	input  logic            median_stall,
	output pdm_pkg::cmd_t   cmd,
	input  pdm_pkg::stat_t  stat,
	output logic [FW-1:0]   wr_addr_f,
	output logic [SW-1:0]   wr_addr_s,
	output logic [FW-1:0]   rd_addr_f,
	output logic [SW-1:0]   rd_addr_s
);
	import pdm_pkg::*;

	localparam int LW = $clog2(MAX_FIRST + MAX_SECOND + 1);

	typedef enum logic [6:0] {
		ST_LOAD = 7'b0000001,
		ST_CAND = 7'b0000010,
		ST_RDC  = 7'b0000100,
		ST_SRD  = 7'b0001000,
		ST_SACC = 7'b0010000,
		ST_EVAL = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [LW-1:0] ld_q, ld_d, ld_sec;
	logic [FW-1:0] ci_q, ci_d, i_q, i_d;
	logic [SW-1:0] cj_q, cj_d, j_q, j_d;
	logic out_valid_q, out_valid_d;
	logic take, in_first, last_ld, j_last, i_last, cj_last;

	assign take     = sample_valid && !sample_stall;
	assign in_first = ld_q < LW'(f_cnt);
	assign last_ld  = (ld_q + LW'(1)) == (LW'(f_cnt) + LW'(s_cnt));
	assign ld_sec   = ld_q - LW'(f_cnt);
	assign j_last   = (SCW'(j_q) + SCW'(1)) == s_cnt;
	assign i_last   = (FCW'(i_q) + FCW'(1)) == f_cnt;
	assign cj_last  = (SCW'(cj_q) + SCW'(1)) == s_cnt;

	// no word is taken in the cycle a register write restarts the load
	assign sample_stall = (state_q != ST_LOAD) || cfg_wr;
	assign median_valid = out_valid_q;
	assign wr_addr_f    = ld_q[FW-1:0];
	assign wr_addr_s    = ld_sec[SW-1:0];
	assign rd_addr_f    = (state_q == ST_CAND) ? ci_q : i_q;
	assign rd_addr_s    = (state_q == ST_CAND) ? cj_q : j_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		ld_d        = ld_q;
		ci_d        = ci_q;
		cj_d        = cj_q;
		i_d         = i_q;
		j_d         = j_q;
		out_valid_d = out_valid_q && median_stall;
		cmd         = '0;
		case (state_q)
			ST_LOAD: begin
				if (cfg_wr) begin
					ld_d = '0;
				end else if (take) begin
					cmd.wr_first  = in_first;
					cmd.wr_second = !in_first;
					if (last_ld) begin
						ld_d            = '0;
						ci_d            = '0;
						cj_d            = '0;
						cmd.found_clear = 1'b1;
						state_d         = ST_CAND;
					end else begin
						ld_d = ld_q + LW'(1);
					end
				end
			end
			ST_CAND: state_d = ST_RDC;
			ST_RDC: begin
				cmd.cand_latch = 1'b1;
				i_d     = '0;
				j_d     = '0;
				state_d = ST_SRD;
			end
			ST_SRD: state_d = ST_SACC;
			ST_SACC: begin
				cmd.acc_en = 1'b1;
				if (j_last) begin
					j_d = '0;
					i_d = i_q + FW'(1);
					state_d = i_last ? ST_EVAL : ST_SRD;
				end else begin
					j_d = j_q + SW'(1);
					state_d = ST_SRD;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.lo_ok && stat.hi_ok) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_CAND;
					if (cj_last) begin
						cj_d = '0;
						ci_d = ci_q + FW'(1);
					end else begin
						cj_d = cj_q + SW'(1);
					end
				end
			end
			ST_OUT: begin
				if (!out_valid_q) begin
					cmd.result_load = 1'b1;
					out_valid_d     = 1'b1;
					state_d         = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			ld_q        <= '0;
			ci_q        <= '0;
			cj_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ld_q        <= ld_d;
			ci_q        <= ci_d;
			cj_q        <= cj_d;
			i_q         <= i_d;
			j_q         <= j_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// File: rtl/pairwise_difference_median_unit.sv
// Two-sample shift estimate: doubled median of all first-minus-second differences.
// Loading takes one word per cycle unless a register write stalls it; after the
// last word, at most F*S candidates are tried, each by one compare per pair via
// the store read ports; the result is registered once any earlier one is taken.
// Reset (arst_n, async low) clears counts to 1, load position and result valid;
// sample stores hold no reset value.
module pairwise_difference_median_unit #(
	parameter int MAX_FIRST  = 32,
	parameter int MAX_SECOND = 32,
	parameter int VALUE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pdm_pkg::IDX_BITS-1:0]        cfg_index,
	input  logic [pdm_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [VALUE_BITS-1:0]        sample_value,
	output logic                                median_valid,
	input  logic                                median_stall,
	output logic signed [VALUE_BITS+1:0]        median_doubled
);
	import pdm_pkg::*;

	localparam int FW  = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;
	localparam int SW  = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
	localparam int FCW = $clog2(MAX_FIRST + 1) + 1;
	localparam int SCW = $clog2(MAX_SECOND + 1) + 1;

	logic [CFG_BITS-1:0] first_count_q, second_count_q;
	logic [FCW-1:0] f_cnt;
	logic [SCW-1:0] s_cnt;
	logic cfg_wr;
	cmd_t cmd;
	stat_t stat;
	logic [FW-1:0] wr_addr_f, rd_addr_f;
	logic [SW-1:0] wr_addr_s, rd_addr_s;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && (cfg_index == REG_FIRST_COUNT || cfg_index == REG_SECOND_COUNT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= CFG_BITS'(1);
			second_count_q <= CFG_BITS'(1);
		end else if (cfg_valid) begin
			if (cfg_index == REG_FIRST_COUNT)  first_count_q  <= cfg_data;
			if (cfg_index == REG_SECOND_COUNT) second_count_q <= cfg_data;
		end
	end

	assign f_cnt = FCW'(clamp_count(first_count_q, MAX_FIRST));
	assign s_cnt = SCW'(clamp_count(second_count_q, MAX_SECOND));

	pdm_ctrl #(
		.MAX_FIRST(MAX_FIRST), .MAX_SECOND(MAX_SECOND),
		.FW(FW), .SW(SW), .FCW(FCW), .SCW(SCW)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_wr),
		.f_cnt(f_cnt), .s_cnt(s_cnt),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.median_valid(median_valid), .median_stall(median_stall),
		.cmd(cmd), .stat(stat),
		.wr_addr_f(wr_addr_f), .wr_addr_s(wr_addr_s),
		.rd_addr_f(rd_addr_f), .rd_addr_s(rd_addr_s)
	);

	pdm_datapath #(
		.MAX_FIRST(MAX_FIRST), .MAX_SECOND(MAX_SECOND), .VALUE_BITS(VALUE_BITS),
		.FW(FW), .SW(SW), .FCW(FCW), .SCW(SCW)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.sample_value(sample_value),
		.wr_addr_f(wr_addr_f), .wr_addr_s(wr_addr_s),
		.rd_addr_f(rd_addr_f), .rd_addr_s(rd_addr_s),
		.f_cnt(f_cnt), .s_cnt(s_cnt),
		.median_doubled(median_doubled)
	);

endmodule

// File: rtl/pdm_checker.sv
// Port-level checks for the pairwise difference median unit, bound to the top.
// Depends only on the top level's ports.
module pdm_checker #(
	parameter int VALUE_BITS = 24
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         sample_valid,
	input logic                         sample_stall,
	input logic                         median_valid,
	input logic                         median_stall,
	input logic signed [VALUE_BITS+1:0] median_doubled
);

	// a stalled input word stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid)
		else $error("input word withdrawn while stalled");

	// a held result keeps its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		median_valid && median_stall |=> median_valid && $stable(median_doubled))
		else $error("result changed while stalled");

	// a new result only follows a busy period
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(median_valid) |-> $past(sample_stall))
		else $error("result without selection");

	// a taken result is not followed at once by another
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		median_valid && !median_stall |=> !median_valid)
		else $error("result repeated");

endmodule

bind pairwise_difference_median_unit pdm_checker #(.VALUE_BITS(VALUE_BITS)) u_pdm_checker (
	.clk(clk), .arst_n(arst_n),
	.sample_valid(sample_valid), .sample_stall(sample_stall),
	.median_valid(median_valid), .median_stall(median_stall),
	.median_doubled(median_doubled)
);

// File: tb/sv/pairwise_difference_median_unit_tb.sv
// Self-checking testbench for pairwise_difference_median_unit: directed table, then random sets.
// Depends on pdm_pkg and unit RTL; local sort predicts each doubled median not typed in a row.
module pairwise_difference_median_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pdm_pkg::*;

	localparam int MAXF = 32;
	localparam int MAXS = 32;
	localparam int TARGET_WORDS = 1700;
	localparam longint CYCLE_LIMIT = 6000000;
	localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [23:0] sample_value = '0;
	logic median_valid;
	logic median_stall = 1'b0;
	logic signed [25:0] median_doubled;

	pairwise_difference_median_unit DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	longint cyc = 0;
	int errors = 0;
	bit hold_off = 1'b0;
	logic signed [25:0] medians_due[$];

	// cycle count and timeout
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bit want_idle();
		if (cyc >= 60000 && cyc < 90000) return 1'b0;
		return $urandom_range(99) < 9;
	endfunction

	// predictor state
	logic [CFG_BITS-1:0] first_reg = 6'd1, second_reg = 6'd1;
	logic signed [23:0] first_vals[MAXF];
	logic signed [23:0] second_vals[MAXS];
	int load_pos = 0;

	function automatic int eff_count(logic [CFG_BITS-1:0] c, int maxv);
		if (c == 0) return 1;
		if (int'(c) > maxv) return maxv;
		return int'(c);
	endfunction

	// sort all differences, sum the two middle ranks (or double the single one)
	function automatic logic signed [25:0] median_of_differences(int f, int s);
		logic signed [24:0] d[MAXF*MAXS];
		logic signed [24:0] key;
		int n, j;
		n = 0;
		for (int a = 0; a < f; a++)
			for (int b = 0; b < s; b++) begin
				d[n] = 25'(first_vals[a]) - 25'(second_vals[b]);
				n++;
			end
		for (int i = 1; i < n; i++) begin
			key = d[i];
			j = i;
			while (j > 0 && d[j-1] > key) begin
				d[j] = d[j-1];
				j--;
			end
			d[j] = key;
		end
		if (n % 2 == 0) return 26'(d[n/2]) + 26'(d[n/2-1]);
		return 26'(d[n/2]) + 26'(d[n/2]);
	endfunction

	// one accepted word into the predictor
	task automatic take_word(logic signed [23:0] v, bit typed, logic signed [25:0] want);
		int f, s;
		logic signed [25:0] m;
		f = eff_count(first_reg, MAXF);
		s = eff_count(second_reg, MAXS);
		if (load_pos >= f + s) load_pos = 0;
		if (load_pos < f) first_vals[load_pos] = v;
		else second_vals[load_pos - f] = v;
		load_pos++;
		if (load_pos == f + s) begin
			load_pos = 0;
			m = median_of_differences(f, s);
			medians_due.push_back(typed ? want : m);
		end
	endtask

	task automatic send_word(logic signed [23:0] v, bit typed = 1'b0,
			logic signed [25:0] want = '0);
		@(negedge clk);
		while (want_idle()) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid = 1'b1;
		sample_value = v;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		take_word(v, typed, want);
	endtask

	// register write once the unit has drained
	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		@(negedge clk);
		sample_valid = 1'b0;
		while (medians_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_FIRST_COUNT) begin
			first_reg = val;
			load_pos = 0;
		end else if (idx == REG_SECOND_COUNT) begin
			second_reg = val;
			load_pos = 0;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [23:0] rand_value();
		case ($urandom_range(9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($signed($urandom_range(16)) - 8);
			default: return 24'($urandom);
		endcase
	endfunction

	// receiver side stall, with one long hold-off
	always @(negedge clk) median_stall <= hold_off ? 1'b1 : want_idle();

	initial begin
		repeat (4000) @(posedge clk);
		hold_off = 1'b1;
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
	end

	// compare each accepted median word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && median_valid && !median_stall) begin
			if (medians_due.size() == 0) begin
				$display("%0t: unexpected median word, actual %0d", $realtime, median_doubled);
				errors++;
			end else begin
				if (median_doubled !== medians_due[0]) begin
					$display("%0t: median mismatch, expected %0d actual %0d",
						$realtime, medians_due[0], median_doubled);
					errors++;
				end
				void'(medians_due.pop_front());
			end
		end
	end

	typedef struct {
		bit is_cfg;
		logic [IDX_BITS-1:0] idx;
		logic [CFG_BITS-1:0] data;
		logic signed [23:0] value;
		bit typed;
		logic signed [25:0] want;
	} row_t;

	row_t rows[21];
	int words_sent;
	int f, s, sets, part;

	initial begin
		// directed rows: extremes, ignored index, restart by write, zero count
		rows[0]  = '{0, 0, 0, 24'sh7FFFFF, 0, 0};
		rows[1]  = '{0, 0, 0, 24'sh800000, 1, 26'sd33554430};
		rows[2]  = '{0, 0, 0, 24'sh800000, 0, 0};
		rows[3]  = '{0, 0, 0, 24'sh7FFFFF, 1, -26'sd33554430};
		rows[4]  = '{0, 0, 0, 24'sd0, 0, 0};
		rows[5]  = '{0, 0, 0, 24'sd0, 1, 26'sd0};
		rows[6]  = '{1, REG_FIRST_COUNT, 6'd2, 0, 0, 0};
		rows[7]  = '{1, REG_SECOND_COUNT, 6'd2, 0, 0, 0};
		rows[8]  = '{0, 0, 0, 24'sd5, 0, 0};
		rows[9]  = '{0, 0, 0, -24'sd3, 0, 0};
		rows[10] = '{0, 0, 0, 24'sd1, 0, 0};
		rows[11] = '{0, 0, 0, 24'sd9, 0, 0};
		rows[12] = '{1, REG_UNUSED, 6'd7, 0, 0, 0};
		rows[13] = '{0, 0, 0, 24'sd100, 0, 0};
		rows[14] = '{1, REG_SECOND_COUNT, 6'd0, 0, 0, 0};
		rows[15] = '{0, 0, 0, -24'sd1, 0, 0};
		rows[16] = '{0, 0, 0, 24'sd4, 0, 0};
		rows[17] = '{0, 0, 0, 24'sd2, 0, 0};
		rows[18] = '{1, REG_FIRST_COUNT, 6'd0, 0, 0, 0};
		rows[19] = '{0, 0, 0, 24'sd10, 0, 0};
		rows[20] = '{0, 0, 0, -24'sd4, 1, 26'sd28};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].data);
			else send_word(rows[i].value, rows[i].typed, rows[i].want);
		end

		// random phases of sets; mostly small counts, a few at the extremes
		words_sent = 0;
		while (words_sent < TARGET_WORDS) begin
			part = $urandom_range(99);
			if (part < 4) begin
				f = 63; s = 1;
			end else if (part < 8) begin
				f = 32; s = $urandom_range(2, 0);
			end else if (part < 12) begin
				f = 1; s = 32;
			end else if (part < 16) begin
				f = 0; s = 0;
			end else if (part < 20) begin
				f = $urandom_range(8, 5); s = $urandom_range(6, 1);
			end else begin
				f = $urandom_range(5, 1); s = $urandom_range(5, 1);
			end
			write_reg(REG_FIRST_COUNT, CFG_BITS'(f));
			write_reg(REG_SECOND_COUNT, CFG_BITS'(s));
			if ($urandom_range(9) == 0)
				write_reg(IDX_BITS'(REG_UNUSED + $urandom_range(1) - 1), 6'($urandom));
			sets = $urandom_range(8, 2);
			for (int k = 0; k < sets; k++) begin
				if ($urandom_range(19) == 0 &&
						eff_count(CFG_BITS'(f), MAXF) + eff_count(CFG_BITS'(s), MAXS) > 1) begin
					// broken set: partial load, then a write restarts it
					repeat ($urandom_range(eff_count(CFG_BITS'(f), MAXF) +
							eff_count(CFG_BITS'(s), MAXS) - 1, 1))
						send_word(rand_value());
					write_reg(REG_SECOND_COUNT, CFG_BITS'(s));
				end
				for (int w = 0; w < eff_count(CFG_BITS'(f), MAXF) +
						eff_count(CFG_BITS'(s), MAXS); w++) begin
					send_word(rand_value());
					words_sent++;
				end
			end
		end

		@(negedge clk);
		sample_valid = 1'b0;
		while (medians_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
